FILE: rtl/bdld_pkg.sv
// ----------------------------------------------------------------------------
// bdld_pkg: shared constants and types of the Bayer demosaic / downsample unit
// Field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package bdld_pkg;

   localparam int PIX_W        = 8;
   localparam int CFG_PHASE_W  = 2;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 2;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam logic [CFG_PHASE_W-1:0]  RST_BAYER_PHASE  = 2'd0;
   localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd960;
   localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 12'd1280;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BAYER_PHASE  = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_index_type;

endpackage

FILE: rtl/bdld_req_if.sv
// ----------------------------------------------------------------------------
// bdld_req_if: raw pixel channel
// Valid/ready channel that carries one raw Bayer sample per beat.
// ----------------------------------------------------------------------------
interface bdld_req_if import bdld_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] raw_pixel;

   modport source (output valid, output raw_pixel, input ready);
   modport sink   (input valid, input raw_pixel, output ready);
endinterface

FILE: rtl/bdld_rsp_if.sv
// ----------------------------------------------------------------------------
// bdld_rsp_if: downsampled RGB channel
// Valid/ready channel that carries one half-resolution RGB pixel per beat.
// ----------------------------------------------------------------------------
interface bdld_rsp_if import bdld_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_value;
   logic [PIX_W-1:0] green_value;
   logic [PIX_W-1:0] blue_value;
   logic             end_of_row;
   logic             end_of_frame;

   modport source (output valid, output red_value, output green_value, output blue_value,
                   output end_of_row, output end_of_frame, input ready);
   modport sink   (input valid, input red_value, input green_value, input blue_value,
                   input end_of_row, input end_of_frame, output ready);
endinterface

FILE: rtl/bayer_demosaic_lowpass_downsample_unit.sv
// ----------------------------------------------------------------------------
// bayer_demosaic_lowpass_downsample_unit: bilinear demosaic, 2x2 box, 2:1 decimate
// Raw Bayer stream in, half-resolution RGB out, four-row line memory.
// ----------------------------------------------------------------------------
//   channel     direction  beat
//   req_stream  in         one raw pixel, raster order
//   rsp_stream  out        one RGB pixel + end_of_row / end_of_frame
//   csr_*       in         register write (index, data), no read-back
//
// One raw pixel is taken every cycle while the input is not stalled; the single
// line-memory word per column (four rows packed) is read at accept and written
// back by stage s1. Results pass the s1, window and s3 site registers to output.
// Reset is synchronous; the line memory needs no clearing, every row a result
// uses is written in the current frame. The input stalls only when a result must
// enter the output register while it still holds an untaken beat.
// ----------------------------------------------------------------------------
module bayer_demosaic_lowpass_downsample_unit
   import bdld_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   bdld_req_if.sink               req_stream,
   bdld_rsp_if.source             rsp_stream,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int WCW = (XW + 1 > CFG_WIDTH_W) ? XW + 1 : CFG_WIDTH_W;
   localparam int HCW = (YW + 1 > CFG_HEIGHT_W) ? YW + 1 : CFG_HEIGHT_W;
   localparam logic [WCW-1:0] MAX_W_EVEN = WCW'(MAX_WIDTH & ~1);
   localparam logic [HCW-1:0] MAX_H_EVEN = HCW'(MAX_HEIGHT & ~1);

   typedef logic [3:0][PIX_W-1:0] col_type;      // [row], row 0 on top
   typedef logic [3:0][3:0][PIX_W-1:0] win_type; // [row][col]
   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
   } rgb_type;
   typedef struct packed {
      logic emit;
      logic eor;
      logic eof;
      logic hfirst;
      logic hlast;
   } ctl_type;

   // bilinear demosaic of one site of the 4x4 window
   function automatic rgb_type demosaic_site(input win_type q, input int i, input int j,
                                             input logic [1:0] phase);
      logic [PIX_W+1:0] s_nesw;
      logic [PIX_W+1:0] s_diag;
      logic [PIX_W:0]   s_vert;
      logic [PIX_W:0]   s_horz;
      logic [PIX_W-1:0] p, nesw, diag, vert, horz;
      logic             red_row, red_col;
      rgb_type          res;
      p      = q[j][i];
      s_nesw = {2'b0, q[j][i-1]} + {2'b0, q[j][i+1]} + {2'b0, q[j-1][i]} + {2'b0, q[j+1][i]};
      s_diag = {2'b0, q[j-1][i-1]} + {2'b0, q[j-1][i+1]}
             + {2'b0, q[j+1][i-1]} + {2'b0, q[j+1][i+1]};
      s_vert = {1'b0, q[j-1][i]} + {1'b0, q[j+1][i]};
      s_horz = {1'b0, q[j][i-1]} + {1'b0, q[j][i+1]};
      nesw   = s_nesw[PIX_W+1:2];
      diag   = s_diag[PIX_W+1:2];
      vert   = s_vert[PIX_W:1];
      horz   = s_horz[PIX_W:1];
      red_row = (j == 2) ? phase[1] : !phase[1];
      red_col = (i == 2) ? phase[0] : !phase[0];
      res.r = red_row ? (red_col ? p : horz) : (red_col ? vert : diag);
      res.g = red_row ? (red_col ? nesw : p) : (red_col ? p : nesw);
      res.b = red_row ? (red_col ? diag : vert) : (red_col ? horz : p);
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIX_W:1];
   endfunction

   // configuration registers and frame counters
   logic [CFG_PHASE_W-1:0]  phase_ff;
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [XW-1:0]           column_count_ff, column_count_in;
   logic [YW-1:0]           row_count_ff, row_count_in;

   logic [WCW-1:0] eff_w, w_even;
   logic [HCW-1:0] eff_h, h_even;
   logic           last_col, last_row, emit_x, emit_y, accept, adv;
   ctl_type        s0_ctl;

   // pipeline registers
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [XW-1:0]    s1_x_ff;
   logic [1:0]       s1_slot_ff;
   logic             s1_vfirst_ff, s1_vlast_ff;
   ctl_type          s1_ctl_ff;
   col_type          rd_word_ff;
   logic             s2_valid_ff;
   ctl_type          s2_ctl_ff;
   win_type          window_ff;   // [col][row], col 3 newest
   win_type          window_in;
   logic             s3_valid_ff;
   ctl_type          s3_ctl_ff;
   rgb_type          s3_site_ff [4];
   rgb_type          site_in [4];

   logic             out_valid_ff;
   rgb_type          out_rgb_ff;
   logic             out_eor_ff, out_eof_ff;

   col_type          row_mem [MAX_WIDTH];
   col_type          new_word, new_col;
   win_type          q;
   int               csel [4];

   // effective geometry: even, saturated to the supported range
   always_comb begin
      w_even = WCW'(width_ff & ~CFG_WIDTH_W'(1));
      if (w_even > MAX_W_EVEN) eff_w = MAX_W_EVEN;
      else if (w_even < WCW'(4)) eff_w = WCW'(4);
      else eff_w = w_even;
      h_even = HCW'(height_ff & ~CFG_HEIGHT_W'(1));
      if (h_even > MAX_H_EVEN) eff_h = MAX_H_EVEN;
      else if (h_even < HCW'(4)) eff_h = HCW'(4);
      else eff_h = h_even;
   end

   // stall only when a result would overrun a waiting output beat
   assign adv    = !(s3_valid_ff && s3_ctl_ff.emit && out_valid_ff && !rsp_stream.ready);
   assign accept = req_stream.valid && adv;
   assign req_stream.ready = adv;

   // position flags of the incoming pixel
   always_comb begin
      last_col = (WCW'(column_count_ff) == eff_w - WCW'(1));
      last_row = (HCW'(row_count_ff) == eff_h - HCW'(1));
      emit_x   = last_col || (!column_count_ff[0] && column_count_ff != '0);
      emit_y   = last_row || (!row_count_ff[0] && row_count_ff != '0);
      s0_ctl.emit   = emit_x && emit_y;
      s0_ctl.eor    = last_col;
      s0_ctl.eof    = last_col && last_row;
      s0_ctl.hfirst = (column_count_ff == XW'(2));
      s0_ctl.hlast  = last_col;
      column_count_in = column_count_ff + XW'(1);
      row_count_in    = row_count_ff;
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : row_count_ff + YW'(1);
      end
   end

   // registers and counters; geometry writes restart the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= RST_BAYER_PHASE;
         width_ff        <= RST_FRAME_WIDTH;
         height_ff       <= RST_FRAME_HEIGHT;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_BAYER_PHASE: begin
               phase_ff <= csr_write_data[CFG_PHASE_W-1:0];
            end
            REG_FRAME_WIDTH: begin
               width_ff        <= csr_write_data[CFG_WIDTH_W-1:0];
               column_count_ff <= '0;
               row_count_ff    <= '0;
            end
            REG_FRAME_HEIGHT: begin
               height_ff       <= csr_write_data[CFG_HEIGHT_W-1:0];
               column_count_ff <= '0;
               row_count_ff    <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // line memory: read at accept, write the merged word back from stage s1
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_word_ff <= row_mem[column_count_ff];
         if (s1_valid_ff) row_mem[s1_x_ff] <= new_word;
      end
   end

   // merge the new pixel and pick the four rows, clamped at top and bottom
   always_comb begin
      logic [1:0] m1, m2, m3;
      m1 = s1_slot_ff - 2'd1;
      m2 = s1_slot_ff - 2'd2;
      m3 = s1_slot_ff - 2'd3;
      new_word = rd_word_ff;
      new_word[s1_slot_ff] = s1_pix_ff;
      new_col[3] = new_word[s1_slot_ff];
      if (s1_vlast_ff) begin
         new_col[0] = new_word[m2];
         new_col[1] = new_word[m1];
         new_col[2] = new_word[s1_slot_ff];
      end else if (s1_vfirst_ff) begin
         new_col[0] = new_word[m2];
         new_col[1] = new_word[m2];
         new_col[2] = new_word[m1];
      end else begin
         new_col[0] = new_word[m3];
         new_col[1] = new_word[m2];
         new_col[2] = new_word[m1];
      end
      window_in = {new_col, window_ff[3:1]};
   end

   // pick window columns, clamped at left and right edges, then demosaic
   always_comb begin
      if (s2_ctl_ff.hfirst) begin
         csel[0] = 1; csel[1] = 1; csel[2] = 2; csel[3] = 3;
      end else if (s2_ctl_ff.hlast) begin
         csel[0] = 1; csel[1] = 2; csel[2] = 3; csel[3] = 3;
      end else begin
         csel[0] = 0; csel[1] = 1; csel[2] = 2; csel[3] = 3;
      end
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            q[j][i] = window_ff[csel[i]][j];
         end
      end
      site_in[0] = demosaic_site(q, 1, 1, phase_ff);
      site_in[1] = demosaic_site(q, 2, 1, phase_ff);
      site_in[2] = demosaic_site(q, 1, 2, phase_ff);
      site_in[3] = demosaic_site(q, 2, 2, phase_ff);
   end

   // advance the pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            if (s1_valid_ff) window_ff <= window_in;
         end
         if (adv && s3_valid_ff && s3_ctl_ff.emit) out_valid_ff <= 1'b1;
         else if (rsp_stream.ready) out_valid_ff <= 1'b0;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pix_ff    <= req_stream.raw_pixel;
         s1_x_ff      <= column_count_ff;
         s1_slot_ff   <= row_count_ff[1:0];
         s1_vfirst_ff <= (row_count_ff == YW'(2));
         s1_vlast_ff  <= last_row;
         s1_ctl_ff    <= s0_ctl;
         s2_ctl_ff    <= s1_ctl_ff;
         s3_ctl_ff    <= s2_ctl_ff;
         for (int k = 0; k < 4; k++) s3_site_ff[k] <= site_in[k];
         if (s3_valid_ff && s3_ctl_ff.emit) begin
            out_rgb_ff.r <= avg2(avg2(s3_site_ff[0].r, s3_site_ff[1].r),
                                 avg2(s3_site_ff[2].r, s3_site_ff[3].r));
            out_rgb_ff.g <= avg2(avg2(s3_site_ff[0].g, s3_site_ff[1].g),
                                 avg2(s3_site_ff[2].g, s3_site_ff[3].g));
            out_rgb_ff.b <= avg2(avg2(s3_site_ff[0].b, s3_site_ff[1].b),
                                 avg2(s3_site_ff[2].b, s3_site_ff[3].b));
            out_eor_ff   <= s3_ctl_ff.eor;
            out_eof_ff   <= s3_ctl_ff.eof;
         end
      end
   end

   assign rsp_stream.valid        = out_valid_ff;
   assign rsp_stream.red_value    = out_rgb_ff.r;
   assign rsp_stream.green_value  = out_rgb_ff.g;
   assign rsp_stream.blue_value   = out_rgb_ff.b;
   assign rsp_stream.end_of_row   = out_eor_ff;
   assign rsp_stream.end_of_frame = out_eof_ff;

   // counters stay inside the frame
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      WCW'(column_count_ff) < eff_w)
      else $error("column counter outside frame");
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      HCW'(row_count_ff) < eff_h)
      else $error("row counter outside frame");
   // a frame ends on a row end
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_eof_ff |-> out_eor_ff)
      else $error("end_of_frame without end_of_row");
   // a stalled result never loses the waiting beat
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_ctl_ff.emit && out_valid_ff && !rsp_stream.ready |=> out_valid_ff)
      else $error("output beat dropped");

endmodule
